/* rtl/core/vfu_pkg.sv */
// shared types and constants for the vortex force velocity update block
// no dependencies
package vfu_pkg;

  localparam int PosW   = 16;
  localparam int VelW   = 24;
  localparam int ReachW = 15;
  localparam int GainW  = 16;
  localparam int CfgDW  = 32;
  localparam int CfgAW  = 5;

  // datapath widths
  localparam int D2W    = 2 * ReachW;        // squared distance inside reach
  localparam int DistW  = ReachW;            // integer root
  localparam int FallW  = 16;                // falloff, q0.16
  localparam int DenW   = DistW + 8;         // dist * 256
  localparam int QuoW   = 27;                // planar accel quotient
  localparam int NumW   = DenW + QuoW;       // accel numerator

  localparam logic [ReachW-1:0] ReachRst = ReachW'(6720);
  localparam logic [GainW-1:0]  SwirlRst = GainW'(900);
  localparam logic [GainW-1:0]  PullRst  = GainW'(500);
  localparam logic [GainW-1:0]  LiftRst  = GainW'(1400);
  localparam logic [GainW-1:0]  StepRst  = GainW'(1092);

  typedef enum logic [2:0] {
    REG_REACH = 3'd0,
    REG_SWIRL = 3'd1,
    REG_PULL  = 3'd2,
    REG_LIFT  = 3'd3,
    REG_STEP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [PosW-1:0] core_x;
    logic signed [PosW-1:0] core_y;
  } vfu_in_t;

  typedef struct packed {
    logic signed [VelW-1:0] new_vel_x;
    logic signed [VelW-1:0] new_vel_y;
    logic                   in_reach;
  } vfu_out_t;

endpackage

/* rtl/core/vortex_force_velocity_update.sv */
// top level of the vortex force velocity update kernel
// depends on vfu_pkg, vfu_sqrt and vfu_div
//
// usage
//   one particle word per cycle enters on in_data (in_valid / in_stall) and one
//   velocity word leaves on out_data (out_valid / out_stall) for each particle,
//   in order. a word moves when valid is high and stall is low.
//   registers sit on an apb-style port (psel/penable/pwrite/paddr/pwdata,
//   pready tied high, prdata reads back); register i is at byte address 4*i.
//   write them only while no particle is in flight.
// throughput and depth
//   a new particle can be taken every cycle while in_stall is low. the
//   pipeline depth comes from the 15-stage root, the 16-stage falloff
//   divider and the 27-stage accel dividers, one bit per stage.
// reset
//   rst_n (synchronous) empties every stage and loads the default reach, gains and step.
// stall
//   the whole pipe advances together; a two-word output buffer takes the word
//   made while out_stall holds; the pipe and in_stall (driven from a register) freeze once it is full.
module vortex_force_velocity_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  vfu_pkg::vfu_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output vfu_pkg::vfu_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vfu_pkg::CfgAW-1:0]   paddr,
  input  logic [vfu_pkg::CfgDW-1:0]   pwdata,
  output logic [vfu_pkg::CfgDW-1:0]   prdata,
  output logic                        pready
);

  import vfu_pkg::*;

  localparam int RW   = PosW + 1;          // offset from core
  localparam int PrW  = 2 * RW;            // offset times gain
  localparam int NxW  = PrW;               // planar numerator
  localparam int PnW  = NumW;              // numerator times falloff
  localparam int LfW  = GainW + FallW;
  localparam int Lf2W = LfW + FallW;
  localparam int LqW  = Lf2W - 23;         // rounded lift term
  localparam int AccW = QuoW + 2;
  localparam int PaW  = AccW + GainW + 1;  // accel times time step
  localparam int DvW  = PaW - 15;
  localparam int SumW = DvW + 1;
  localparam int SqSW = 1 + 2 * NxW + 2 * VelW;
  localparam int FdSW = DistW + SqSW;
  localparam int DxSW = 1 + LqW + 1 + 2 * VelW;

  // ---------------------------------------------------------------- config
  logic [ReachW-1:0] reach_r;
  logic [GainW-1:0]  swirl_r;
  logic [GainW-1:0]  pull_r;
  logic [GainW-1:0]  lift_r;
  logic [GainW-1:0]  step_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CfgAW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= ReachRst;
      swirl_r <= SwirlRst;
      pull_r  <= PullRst;
      lift_r  <= LiftRst;
      step_r  <= StepRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REACH: reach_r <= pwdata[ReachW-1:0];
        REG_SWIRL: swirl_r <= pwdata[GainW-1:0];
        REG_PULL:  pull_r  <= pwdata[GainW-1:0];
        REG_LIFT:  lift_r  <= pwdata[GainW-1:0];
        REG_STEP:  step_r  <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REACH: prdata = CfgDW'(reach_r);
      REG_SWIRL: prdata = CfgDW'(swirl_r);
      REG_PULL:  prdata = CfgDW'(pull_r);
      REG_LIFT:  prdata = CfgDW'(lift_r);
      REG_STEP:  prdata = CfgDW'(step_r);
      default:   prdata = '0;
    endcase
  end

  // ------------------------------------------------------- pipe enable
  // the pipe only freezes once the output buffer holds two words
  logic     en;
  logic     skid_valid_r;
  vfu_out_t skid_word_r;
  logic     out_valid_r;
  vfu_out_t out_word_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // ---------------------------------------------------- s1: core offset
  logic                   s1_valid_r;
  logic signed [RW-1:0]   s1_rx_r, s1_ry_r;
  logic signed [VelW-1:0] s1_vx_r, s1_vy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rx_r <= RW'(in_data.pos_x) - RW'(in_data.core_x);
      s1_ry_r <= RW'(in_data.pos_y) - RW'(in_data.core_y);
      s1_vx_r <= in_data.vel_x;
      s1_vy_r <= in_data.vel_y;
    end
  end

  // ------------------------------------ s2: squares and gain products
  logic signed [RW-1:0]   swirl_s, pull_s;
  logic signed [PrW-1:0]  sqx_c, sqy_c;
  logic                   s2_valid_r;
  logic [PrW-2:0]         s2_sqx_r, s2_sqy_r;
  logic signed [PrW-1:0]  s2_rxgs_r, s2_rxgp_r, s2_rygs_r, s2_rygp_r;
  logic [D2W-1:0]         s2_rsq_r;
  logic signed [VelW-1:0] s2_vx_r, s2_vy_r;

  assign swirl_s = $signed({1'b0, swirl_r});
  assign pull_s  = $signed({1'b0, pull_r});
  assign sqx_c   = s1_rx_r * s1_rx_r;
  assign sqy_c   = s1_ry_r * s1_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r  <= sqx_c[PrW-2:0];
      s2_sqy_r  <= sqy_c[PrW-2:0];
      s2_rxgs_r <= s1_rx_r * swirl_s;
      s2_rxgp_r <= s1_rx_r * pull_s;
      s2_rygs_r <= s1_ry_r * swirl_s;
      s2_rygp_r <= s1_ry_r * pull_s;
      s2_rsq_r  <= D2W'(reach_r) * D2W'(reach_r);
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
    end
  end

  // --------------------- s3: distance squared, reach test, swirl and pull
  logic [PrW-1:0]         d2_c;
  logic                   s3_valid_r;
  logic                   s3_hit_r;
  logic [D2W-1:0]         s3_d2_r;
  logic signed [NxW-1:0]  s3_nx_r, s3_ny_r;
  logic signed [VelW-1:0] s3_vx_r, s3_vy_r;

  assign d2_c = PrW'(s2_sqx_r) + PrW'(s2_sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  // offsets outside reach are never used, so the planar sums keep PrW bits
  always_ff @(posedge clk) begin
    if (en) begin
      s3_hit_r <= (d2_c != '0) && (d2_c < PrW'(s2_rsq_r));
      s3_d2_r  <= d2_c[D2W-1:0];
      s3_nx_r  <= -s2_rygs_r - s2_rxgp_r;
      s3_ny_r  <= s2_rxgs_r - s2_rygp_r;
      s3_vx_r  <= s2_vx_r;
      s3_vy_r  <= s2_vy_r;
    end
  end

  // ------------------------------------------------------ distance root
  logic              sq_valid;
  logic [DistW-1:0]  sq_root;
  logic [SqSW-1:0]   sq_side;

  vfu_sqrt #(
    .VW (D2W),
    .SW (SqSW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_val    (s3_d2_r),
    .in_side   ({s3_hit_r, s3_nx_r, s3_ny_r, s3_vx_r, s3_vy_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ------------------------------ falloff = (reach - dist) * 2^16 / reach
  logic              fd_valid;
  logic [FallW-1:0]  fd_quo;
  logic [FdSW-1:0]   fd_side;
  logic [DistW-1:0]  fd_dist;
  logic              fd_hit;
  logic signed [NxW-1:0]  fd_nx, fd_ny;
  logic signed [VelW-1:0] fd_vx, fd_vy;

  vfu_div #(
    .DW (ReachW),
    .QW (FallW),
    .SW (FdSW)
  ) u_fall_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    ({reach_r - sq_root, {FallW{1'b0}}}),
    .in_den    (reach_r),
    .in_side   ({sq_root, sq_side}),
    .out_valid (fd_valid),
    .out_quo   (fd_quo),
    .out_side  (fd_side)
  );

  assign {fd_dist, fd_hit, fd_nx, fd_ny, fd_vx, fd_vy} = fd_side;

  // ---------------------------------------- s4: products with falloff
  logic signed [NxW+FallW:0] pnx_c, pny_c;
  logic                   s4_valid_r;
  logic                   s4_hit_r;
  logic signed [PnW-1:0]  s4_pnx_r, s4_pny_r;
  logic [LfW-1:0]         s4_lf_r;
  logic [FallW-1:0]       s4_f_r;
  logic [DistW-1:0]       s4_dist_r;
  logic signed [VelW-1:0] s4_vx_r, s4_vy_r;

  assign pnx_c = fd_nx * $signed({1'b0, fd_quo});
  assign pny_c = fd_ny * $signed({1'b0, fd_quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= fd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hit_r  <= fd_hit;
      s4_pnx_r  <= pnx_c[PnW-1:0];
      s4_pny_r  <= pny_c[PnW-1:0];
      s4_lf_r   <= LfW'(lift_r) * LfW'(fd_quo);
      s4_f_r    <= fd_quo;
      s4_dist_r <= fd_dist;
      s4_vx_r   <= fd_vx;
      s4_vy_r   <= fd_vy;
    end
  end

  // ---- s5: magnitudes with half-divisor bias, lift times falloff squared
  logic                   s5_valid_r;
  logic                   s5_hit_r;
  logic                   s5_sx_r, s5_sy_r;
  logic [NumW-1:0]        s5_numx_r, s5_numy_r;
  logic [DenW-1:0]        s5_den_r;
  logic [Lf2W-1:0]        s5_lf2_r;
  logic signed [VelW-1:0] s5_vx_r, s5_vy_r;
  logic [NumW-1:0]        bias_c;
  logic                   sx_c, sy_c;

  assign bias_c = NumW'({s4_dist_r, 7'b0});
  assign sx_c   = s4_pnx_r[PnW-1];
  assign sy_c   = s4_pny_r[PnW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  // |p| + dist*128 as one add with the negation carry folded in
  always_ff @(posedge clk) begin
    if (en) begin
      s5_hit_r  <= s4_hit_r;
      s5_sx_r   <= sx_c;
      s5_sy_r   <= sy_c;
      s5_numx_r <= (sx_c ? ~s4_pnx_r : s4_pnx_r) + bias_c + NumW'(sx_c);
      s5_numy_r <= (sy_c ? ~s4_pny_r : s4_pny_r) + bias_c + NumW'(sy_c);
      s5_den_r  <= {s4_dist_r, 8'b0};
      s5_lf2_r  <= Lf2W'(s4_lf_r) * Lf2W'(s4_f_r);
      s5_vx_r   <= s4_vx_r;
      s5_vy_r   <= s4_vy_r;
    end
  end

  // ------------------------------------ planar accel dividers, x and y
  logic [LqW-1:0]         liftq_c;
  logic                   dx_valid;
  logic [QuoW-1:0]        dx_quo, dy_quo;
  logic [DxSW-1:0]        dx_side;
  logic                   dy_sign;
  logic                   dx_sign;
  logic [LqW-1:0]         dx_liftq;
  logic                   dx_hit;
  logic signed [VelW-1:0] dx_vx, dx_vy;

  // lift * f^2 / 2^24 rounded; never negative
  assign liftq_c = LqW'(((Lf2W + 1)'(s5_lf2_r) + (Lf2W + 1)'(1 << 23)) >> 24);

  vfu_div #(
    .DW (DenW),
    .QW (QuoW),
    .SW (DxSW)
  ) u_accx_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_valid_r),
    .in_num    (s5_numx_r),
    .in_den    (s5_den_r),
    .in_side   ({s5_sx_r, liftq_c, s5_hit_r, s5_vx_r, s5_vy_r}),
    .out_valid (dx_valid),
    .out_quo   (dx_quo),
    .out_side  (dx_side)
  );

  vfu_div #(
    .DW (DenW),
    .QW (QuoW),
    .SW (1)
  ) u_accy_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_valid_r),
    .in_num    (s5_numy_r),
    .in_den    (s5_den_r),
    .in_side   (s5_sy_r),
    .out_valid (),
    .out_quo   (dy_quo),
    .out_side  (dy_sign)
  );

  assign {dx_sign, dx_liftq, dx_hit, dx_vx, dx_vy} = dx_side;

  // ------------------------------------- s6: signed accel, lift applied
  logic                   s6_valid_r;
  logic                   s6_hit_r;
  logic signed [AccW-1:0] s6_ax_r, s6_ay_r;
  logic signed [VelW-1:0] s6_vx_r, s6_vy_r;
  logic [AccW-1:0]        qx_c, qy_c;

  assign qx_c = AccW'(dx_quo);
  assign qy_c = AccW'(dy_quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_hit_r <= dx_hit;
      s6_ax_r  <= dx_sign ? -qx_c : qx_c;
      s6_ay_r  <= (dy_sign ? ~qy_c : qy_c) + AccW'(dy_sign) - AccW'(dx_liftq);
      s6_vx_r  <= dx_vx;
      s6_vy_r  <= dx_vy;
    end
  end

  // ------------------------------------------ s7: accel times time step
  logic signed [PaW-1:0]  s7_px_r, s7_py_r;
  logic                   s7_valid_r;
  logic                   s7_hit_r;
  logic signed [VelW-1:0] s7_vx_r, s7_vy_r;
  logic signed [GainW:0]  step_s;

  assign step_s = $signed({1'b0, step_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_hit_r <= s6_hit_r;
      s7_px_r  <= s6_ax_r * step_s;
      s7_py_r  <= s6_ay_r * step_s;
      s7_vx_r  <= s6_vx_r;
      s7_vy_r  <= s6_vy_r;
    end
  end

  // ------------------------- s8: round velocity change, ties away from zero
  logic                   s8_valid_r;
  logic                   s8_hit_r;
  logic                   s8_sx_r, s8_sy_r;
  logic [DvW-1:0]         s8_qx_r, s8_qy_r;
  logic signed [VelW-1:0] s8_vx_r, s8_vy_r;
  logic [PaW:0]           magx_c, magy_c;

  assign magx_c = (PaW + 1)'(s7_px_r[PaW-1] ? ~s7_px_r : s7_px_r)
                + (PaW + 1)'(s7_px_r[PaW-1]) + (PaW + 1)'(1 << 15);
  assign magy_c = (PaW + 1)'(s7_py_r[PaW-1] ? ~s7_py_r : s7_py_r)
                + (PaW + 1)'(s7_py_r[PaW-1]) + (PaW + 1)'(1 << 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else if (en) begin
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_hit_r <= s7_hit_r;
      s8_sx_r  <= s7_px_r[PaW-1];
      s8_sy_r  <= s7_py_r[PaW-1];
      s8_qx_r  <= magx_c[PaW:16];
      s8_qy_r  <= magy_c[PaW:16];
      s8_vx_r  <= s7_vx_r;
      s8_vy_r  <= s7_vy_r;
    end
  end

  // ------------------------------ new velocity with saturation to 24 bits
  logic signed [SumW-1:0] sumx_c, sumy_c;
  logic signed [VelW-1:0] satx_c, saty_c;
  vfu_out_t               res_c;

  assign sumx_c = SumW'(s8_vx_r) + (s8_sx_r ? ~SumW'(s8_qx_r) : SumW'(s8_qx_r))
                + SumW'(s8_sx_r);
  assign sumy_c = SumW'(s8_vy_r) + (s8_sy_r ? ~SumW'(s8_qy_r) : SumW'(s8_qy_r))
                + SumW'(s8_sy_r);

  always_comb begin
    if (sumx_c > SumW'($signed({1'b0, {(VelW - 1){1'b1}}}))) begin
      satx_c = {1'b0, {(VelW - 1){1'b1}}};
    end else if (sumx_c < -SumW'($signed({1'b0, 1'b1, {(VelW - 1){1'b0}}}))) begin
      satx_c = {1'b1, {(VelW - 1){1'b0}}};
    end else begin
      satx_c = sumx_c[VelW-1:0];
    end
    if (sumy_c > SumW'($signed({1'b0, {(VelW - 1){1'b1}}}))) begin
      saty_c = {1'b0, {(VelW - 1){1'b1}}};
    end else if (sumy_c < -SumW'($signed({1'b0, 1'b1, {(VelW - 1){1'b0}}}))) begin
      saty_c = {1'b1, {(VelW - 1){1'b0}}};
    end else begin
      saty_c = sumy_c[VelW-1:0];
    end
    // at the core or outside reach the velocity passes through
    res_c.new_vel_x = s8_hit_r ? satx_c : s8_vx_r;
    res_c.new_vel_y = s8_hit_r ? saty_c : s8_vy_r;
    res_c.in_reach  = s8_hit_r;
  end

  // ------------------------------------------ output word and skid word
  logic produce;
  logic take;

  assign produce = en && s8_valid_r;
  assign take    = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (produce) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (!out_valid_r || take) begin
        out_word_r <= res_c;
      end else begin
        skid_word_r <= res_c;
      end
    end else if (take && skid_valid_r) begin
      out_word_r <= skid_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

/* rtl/core/vfu_sqrt.sv */
// pipelined integer square root, one result bit per stage, floor rounding
// depends on nothing; sideband word rides along with each value
module vfu_sqrt #(
  parameter int VW = 30,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [VW-1:0]   in_val,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [VW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int NS = VW / 2;

  logic          valid_r [0:NS];
  logic [VW-1:0] v_r     [0:NS];
  logic [VW-1:0] res_r   [0:NS];
  logic [SW-1:0] side_r  [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= in_val;
      res_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int SH = VW - 2 - 2 * g;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] v_nxt;
    logic [VW-1:0] res_nxt;

    assign trial = {1'b0, res_r[g]} + ((VW + 1)'(1) << SH);
    assign ge    = {1'b0, v_r[g]} >= trial;

    always_comb begin
      if (ge) begin
        v_nxt   = VW'({1'b0, v_r[g]} - trial);
        res_nxt = VW'(({1'b0, res_r[g]} >> 1) + ((VW + 1)'(1) << SH));
      end else begin
        v_nxt   = v_r[g];
        res_nxt = res_r[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g+1] <= 1'b0;
      end else if (en) begin
        valid_r[g+1] <= valid_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1]    <= v_nxt;
        res_r[g+1]  <= res_nxt;
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid = valid_r[NS];
  assign out_root  = res_r[NS][NS-1:0];
  assign out_side  = side_r[NS];

endmodule

/* rtl/core/vfu_div.sv */
// pipelined restoring divider, one quotient bit per stage
// requires num < den << QW; sideband word rides along with each operand pair
module vfu_div #(
  parameter int DW = 15,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW+QW-1:0] in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [QW-1:0]   out_quo,
  output logic [SW-1:0]   out_side
);

  localparam int RW = DW + QW;

  logic          valid_r [0:QW];
  logic [RW-1:0] rem_r   [0:QW];
  logic [DW-1:0] den_r   [0:QW];
  logic [QW-1:0] quo_r   [0:QW];
  logic [SW-1:0] side_r  [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      quo_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int SH = QW - 1 - g;
    logic [RW-1:0] shifted;
    logic          ge;
    logic [RW-1:0] rem_nxt;

    assign shifted = RW'(den_r[g]) << SH;
    assign ge      = rem_r[g] >= shifted;
    assign rem_nxt = ge ? rem_r[g] - shifted : rem_r[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g+1] <= 1'b0;
      end else if (en) begin
        valid_r[g+1] <= valid_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= rem_nxt;
        den_r[g+1]  <= den_r[g];
        quo_r[g+1]  <= {quo_r[g][QW-2:0], ge};
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid = valid_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_side  = side_r[QW];

endmodule
